// ----- rtl/core/lps_pkg.sv -----
package lps_pkg;

  localparam int NUM_PEAKS_DEF = 9;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [3:0]         peak_index;
    logic signed [31:0] center_in;
    logic signed [31:0] amplitude_in;
    logic [30:0]        width_in;
    logic signed [31:0] sample_x;
    logic               last_in;
  } lps_in_t;

  typedef struct packed {
    logic signed [31:0] model_value;
    logic               saturated;
    logic               last_out;
  } lps_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_peak;   // write table entry from input item
    logic start_eval;  // latch x and load sum with the background offset
    logic start_peak;  // compute d^2, w^2 for current peak
    logic mul_num;     // low numerator partial product and denominator
    logic mul_hi;      // add high numerator partial product
    logic div_step;    // one restoring division step
    logic accum;       // add signed quotient to sum
    logic next_peak;   // advance peak pointer
    logic finish;      // saturate and load output register
  } lps_cmd_t;

  typedef struct packed {
    logic last_peak;
    logic div_done;
  } lps_stat_t;

endpackage

// ----- rtl/core/lorentzian_peak_sum.sv -----
// An evaluate item runs through every peak in turn, then saturation and the output register.
// Each peak: squares, two numerator partial products, 32 steps of the
// shared restoring divider, and the accumulate.
// No new item is taken while an evaluate item is in progress; a load item does not start one.
// The next item is taken in the cycle the result leaves.
// Reset (rst, synchronous) clears control, the background offset and all peak entry valid bits.
module lorentzian_peak_sum #(
  parameter int NUM_PEAKS = lps_pkg::NUM_PEAKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lps_pkg::lps_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lps_pkg::lps_out_t out_data,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data
);
  import lps_pkg::*;

  lps_cmd_t           cmd;
  lps_stat_t          stat;
  logic signed [31:0] background_offset;

  // Offset register
  always_ff @(posedge clk) begin
    if (rst) background_offset <= '0;
    else if (cfg_we) background_offset <= cfg_data;
  end

  lps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_data.operation), .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  lps_datapath_rst #(.NUM_PEAKS(NUM_PEAKS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_item(in_data),
    .background_offset(background_offset), .out_item(out_data)
  );

endmodule

// ----- rtl/core/lps_datapath.sv -----
module lps_datapath #(
  parameter int NUM_PEAKS = lps_pkg::NUM_PEAKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  lps_pkg::lps_cmd_t cmd,
  output lps_pkg::lps_stat_t stat,
  input  lps_pkg::lps_in_t  in_item,
  input  logic signed [31:0] background_offset,
  output lps_pkg::lps_out_t out_item
);
  import lps_pkg::*;

  localparam int PW = (NUM_PEAKS > 1) ? $clog2(NUM_PEAKS) : 1;
  // Term format follows amplitude, so the fraction width does not enter the math.

  logic signed [31:0] ctab [NUM_PEAKS];
  logic signed [31:0] atab [NUM_PEAKS];
  logic [30:0]        wtab [NUM_PEAKS];
  logic [NUM_PEAKS-1:0] vld;

  logic [PW-1:0]      pk;
  logic signed [31:0] x;
  logic               last_q;
  logic signed [36:0] sum;
  logic [61:0]        w2;
  logic [63:0]        d2;
  logic [31:0]        aa;
  logic               neg;
  logic               wz;
  logic [93:0]        rem;
  logic [64:0]        den;
  logic [31:0]        q;
  logic [5:0]         cnt;

  logic signed [31:0] c_rd, a_rd;
  logic [30:0]        w_rd;
  logic signed [32:0] d;
  logic [31:0]        ad;
  logic [96:0]        trial;
  logic [95:0]        den_sh;
  logic signed [36:0] term;
  logic [PW-1:0]      widx;
  logic               widx_ok;

  // Table read; an unwritten entry reads as zero
  always_comb begin
    c_rd = vld[pk] ? ctab[pk] : 32'sd0;
    a_rd = vld[pk] ? atab[pk] : 32'sd0;
    w_rd = vld[pk] ? wtab[pk] : 31'd0;
    d    = 33'(x) - 33'(c_rd);
    ad   = d[32] ? 32'(-d) : d[31:0];
    den_sh = 96'(den) << cnt[4:0];
    trial  = 97'(rem) - 97'(den_sh);
    term   = neg ? -37'(signed'({1'b0, q})) : 37'(signed'({1'b0, q}));
  end

  // Load index decode
  assign widx    = in_item.peak_index[PW-1:0];
  assign widx_ok = ({1'b0, in_item.peak_index} < 5'(NUM_PEAKS));

  // Peak tables
  always_ff @(posedge clk) begin
    if (cmd.load_peak && widx_ok) begin
      ctab[widx] <= in_item.center_in;
      atab[widx] <= in_item.amplitude_in;
      wtab[widx] <= in_item.width_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_eval) begin
      x      <= in_item.sample_x;
      last_q <= in_item.last_in;
      sum    <= 37'(background_offset);
      pk     <= '0;
    end
    if (cmd.next_peak) pk <= pk + PW'(1);
    // Squares: a 31x31 and a 32x32 product
    if (cmd.start_peak) begin
      w2  <= 62'(w_rd) * 62'(w_rd);
      d2  <= 64'(ad) * 64'(ad);
      aa  <= a_rd[31] ? 32'(-33'(a_rd)) : a_rd;
      neg <= a_rd[31];
      wz  <= (w_rd == 31'd0);
    end
    // Numerator aa*w2 as two 32x31 partial products, denominator w2+d2
    if (cmd.mul_num) begin
      rem <= 94'(aa) * 94'(w2[30:0]);
      den <= 65'(w2) + 65'(d2);
      q   <= '0;
      cnt <= 6'd31;
    end
    if (cmd.mul_hi) rem <= rem + ((94'(aa) * 94'(w2[61:31])) << 31);
    // Restoring division, one quotient bit per cycle
    if (cmd.div_step) begin
      if (!trial[96]) begin
        rem <= trial[93:0];
        q[cnt[4:0]] <= 1'b1;
      end
      cnt <= cnt - 6'd1;
    end
    if (cmd.accum && !wz) sum <= sum + term;
    if (cmd.finish) begin
      out_item.last_out <= last_q;
      if (sum > 37'sd2147483647) begin
        out_item.model_value <= 32'h7FFFFFFF;
        out_item.saturated   <= 1'b1;
      end else if (sum < -37'sd2147483648) begin
        out_item.model_value <= 32'h80000000;
        out_item.saturated   <= 1'b1;
      end else begin
        out_item.model_value <= sum[31:0];
        out_item.saturated   <= 1'b0;
      end
    end
  end

  // Entry valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.load_peak && widx_ok) begin
      vld[widx] <= 1'b1;
    end
  end

  assign stat.last_peak = (pk == PW'(NUM_PEAKS - 1));
  assign stat.div_done  = (cnt == 6'd0);

endmodule

// ----- rtl/core/lps_ctrl.sv -----
module lps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  output logic               out_valid,
  input  logic               out_ready,
  input  lps_pkg::lps_stat_t stat,
  output lps_pkg::lps_cmd_t  cmd
);
  import lps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_MUL, S_MULH, S_DIV, S_ACC, S_FIN, S_OUT
  } state_t;
  state_t state;
  logic   acc_go;

  assign in_ready = (state == S_IDLE) || ((state == S_OUT) && out_ready);
  assign out_valid = (state == S_OUT);
  assign acc_go = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.load_peak  = acc_go && (in_op == OP_LOAD);
    cmd.start_eval = acc_go && (in_op == OP_EVAL);
    cmd.start_peak = (state == S_SQ);
    cmd.mul_num    = (state == S_MUL);
    cmd.mul_hi     = (state == S_MULH);
    cmd.div_step   = (state == S_DIV);
    cmd.accum      = (state == S_ACC);
    cmd.next_peak  = (state == S_ACC) && !stat.last_peak;
    cmd.finish     = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE, S_OUT: begin
          if (acc_go && in_op == OP_EVAL) state <= S_SQ;
          else if (state == S_OUT && out_ready) state <= S_IDLE;
        end
        S_SQ:  state <= S_MUL;
        S_MUL: state <= S_MULH;
        S_MULH: state <= S_DIV;
        S_DIV: if (stat.div_done) state <= S_ACC;
        S_ACC: state <= stat.last_peak ? S_FIN : S_SQ;
        S_FIN: state <= S_OUT;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/lps_datapath_rst.sv -----
module lps_datapath_rst #(
  parameter int NUM_PEAKS = lps_pkg::NUM_PEAKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lps_pkg::lps_cmd_t  cmd,
  output lps_pkg::lps_stat_t stat,
  input  lps_pkg::lps_in_t   in_item,
  input  logic signed [31:0] background_offset,
  output lps_pkg::lps_out_t  out_item
);
  import lps_pkg::*;

  // Reset reaches the entry valid bits inside the datapath
  lps_datapath #(.NUM_PEAKS(NUM_PEAKS)) u_core (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_item(in_item),
    .background_offset(background_offset), .out_item(out_item)
  );

endmodule
